### hdl/msc_dgf_pkg.sv
// Shared types, constants and byte/CRC functions for the MSC data group framer.
// Used by msc_dgf_emit, msc_dgf_obuf and msc_data_group_framer.
`timescale 1ns / 1ps

package msc_dgf_pkg;

  localparam int TYPE_W      = 4;
  localparam int SEGN_W      = 15;
  localparam int TID_W       = 16;
  localparam int SLEN_W      = 13;
  localparam int BYTE_W      = 8;
  localparam int CRC_W       = 16;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 8;
  localparam int IDX_W       = 4;

  // Position of the byte being produced within one item's results
  localparam logic [IDX_W-1:0] IDX_FIRST    = 4'd0;
  localparam logic [IDX_W-1:0] IDX_HDR_LAST = 4'd8;
  localparam logic [IDX_W-1:0] IDX_HCRC_HI  = 4'd9;
  localparam logic [IDX_W-1:0] IDX_HCRC_LO  = 4'd10;
  localparam logic [IDX_W-1:0] IDX_DCRC_HI  = 4'd1;
  localparam logic [IDX_W-1:0] IDX_DCRC_LO  = 4'd2;

  // Header byte positions
  localparam logic [IDX_W-1:0] HB_TYPE     = 4'd0;
  localparam logic [IDX_W-1:0] HB_CI       = 4'd1;
  localparam logic [IDX_W-1:0] HB_SEGN_HI  = 4'd2;
  localparam logic [IDX_W-1:0] HB_SEGN_LO  = 4'd3;
  localparam logic [IDX_W-1:0] HB_ACCESS   = 4'd4;
  localparam logic [IDX_W-1:0] HB_TID_HI   = 4'd5;
  localparam logic [IDX_W-1:0] HB_TID_LO   = 4'd6;
  localparam logic [IDX_W-1:0] HB_SLEN_HI  = 4'd7;
  localparam logic [IDX_W-1:0] HB_SLEN_LO  = 4'd8;

  localparam logic [CRC_W-1:0]  CRC_INIT   = 16'hFFFF;
  localparam logic [CRC_W-1:0]  CRC_POLY   = 16'h1021;
  // extension 0, CRC 1, segment 1, user access 1
  localparam logic [BYTE_W-1:0] HDR_FLAGS  = 8'h70;
  // RFA 0, transport id flag 1, length indicator 2
  localparam logic [BYTE_W-1:0] HDR_ACCESS = 8'h12;

  typedef enum logic {
    CMD_HEADER = 1'b0,
    CMD_DATA   = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [TYPE_W-1:0] group_type;
    logic [SEGN_W-1:0] segment_number;
    logic              last_segment;
    logic [TID_W-1:0]  transport_id;
    logic [SLEN_W-1:0] segment_length;
    logic [BYTE_W-1:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              end_of_group;
  } res_t;

  typedef struct packed {
    logic busy;
    logic advance;
    logic done;
  } emit_stat_t;

  // CRC-16-CCITT, MSB first, one byte
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < BYTE_W; i++) begin
      c = c[CRC_W-1] ? ({c[CRC_W-2:0], 1'b0} ^ CRC_POLY) : {c[CRC_W-2:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic [BYTE_W-1:0] hdr_byte(input logic [IDX_W-1:0] idx,
                                                 input item_t it);
    logic [BYTE_W-1:0] b;
    unique case (idx)
      HB_TYPE:    b = HDR_FLAGS | {4'h0, it.group_type};
      HB_CI:      b = {it.segment_number[3:0], 4'h0};
      HB_SEGN_HI: b = {it.last_segment, it.segment_number[14:8]};
      HB_SEGN_LO: b = it.segment_number[7:0];
      HB_ACCESS:  b = HDR_ACCESS;
      HB_TID_HI:  b = it.transport_id[15:8];
      HB_TID_LO:  b = it.transport_id[7:0];
      HB_SLEN_HI: b = {3'b000, it.segment_length[12:8]};
      HB_SLEN_LO: b = it.segment_length[7:0];
      default:    b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

### hdl/msc_dgf_emit.sv
// Holds the current input item and sequences its result bytes, one per step.
// Keeps the running CRC and group state. Depends on msc_dgf_pkg.
`timescale 1ns / 1ps

module msc_dgf_emit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_load,
  input  msc_dgf_pkg::item_t   in_item,
  input  logic                 obuf_ready,
  output msc_dgf_pkg::res_t    res,
  output logic                 res_valid,
  output msc_dgf_pkg::emit_stat_t stat
);
  import msc_dgf_pkg::*;

  logic                busy_r, busy_nxt;
  item_t               item_r;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [CRC_W-1:0]    crc_r, crc_nxt;
  logic [SLEN_W-1:0]   rem_r, rem_nxt;
  logic                open_r, open_nxt;

  logic                is_hdr;
  logic                drop;
  logic                crc_step;
  logic                is_hi;
  logic                is_lo;
  logic                done;
  logic                advance;
  logic [BYTE_W-1:0]   byte_in;
  logic [CRC_W-1:0]    crc_src;
  logic [CRC_W-1:0]    crc_upd;
  logic [CRC_W-1:0]    crc_inv;

  always_comb begin
    is_hdr   = (item_r.cmd == CMD_HEADER);
    // data item with no group open gives no result
    drop     = !is_hdr && (idx_r == IDX_FIRST) && !open_r;
    crc_step = is_hdr ? (idx_r <= IDX_HDR_LAST) : (idx_r == IDX_FIRST);
    is_hi    = (idx_r == (is_hdr ? IDX_HCRC_HI : IDX_DCRC_HI));
    is_lo    = (idx_r == (is_hdr ? IDX_HCRC_LO : IDX_DCRC_LO));
    byte_in  = is_hdr ? hdr_byte(idx_r, item_r) : item_r.data_byte;
    crc_src  = (is_hdr && idx_r == IDX_FIRST) ? CRC_INIT : crc_r;
    crc_upd  = crc_byte(crc_src, byte_in);
    crc_inv  = ~crc_r;

    res.out_byte     = crc_step ? byte_in : (is_hi ? crc_inv[15:8] : crc_inv[7:0]);
    res.end_of_group = is_lo;
    res_valid        = busy_r && !drop;
    advance          = busy_r && (drop || obuf_ready);

    done = drop || is_lo
        || (is_hdr && idx_r == IDX_HDR_LAST && item_r.segment_length != '0)
        || (!is_hdr && idx_r == IDX_FIRST && rem_r != SLEN_W'(1));

    stat.busy    = busy_r;
    stat.advance = advance;
    stat.done    = done;
  end

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    crc_nxt  = crc_r;
    rem_nxt  = rem_r;
    open_nxt = open_r;
    if (advance && !drop) begin
      idx_nxt = done ? IDX_FIRST : idx_r + IDX_W'(1);
      if (crc_step) begin
        crc_nxt = crc_upd;
      end else if (is_lo) begin
        crc_nxt = CRC_INIT;
      end
      if (idx_r == IDX_FIRST) begin
        // group state settles on the first byte; the CRC bytes only read crc_r
        if (is_hdr) begin
          rem_nxt  = item_r.segment_length;
          open_nxt = (item_r.segment_length != '0);
        end else begin
          rem_nxt  = rem_r - SLEN_W'(1);
          open_nxt = (rem_r != SLEN_W'(1));
        end
      end
    end
    if (advance && done) begin
      busy_nxt = 1'b0;
    end
    if (in_load) begin
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= IDX_FIRST;
      crc_r  <= CRC_INIT;
      rem_r  <= '0;
      open_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
      crc_r  <= crc_nxt;
      rem_r  <= rem_nxt;
      open_r <= open_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      item_r <= in_item;
    end
  end

endmodule

### hdl/msc_dgf_obuf.sv
// Output register for the result channel; takes a new item when it is empty or
// when the held one leaves. Depends on msc_dgf_pkg.
`timescale 1ns / 1ps

module msc_dgf_obuf (
  input  logic               clk,
  input  logic               rst_n,
  input  msc_dgf_pkg::res_t  res,
  input  logic               res_valid,
  output logic               obuf_ready,
  input  logic               out_tready,
  output logic               out_tvalid,
  output msc_dgf_pkg::res_t  out_res
);
  import msc_dgf_pkg::*;

  logic valid_r, valid_nxt;
  res_t data_r;

  assign obuf_ready = !valid_r || out_tready;
  assign valid_nxt  = obuf_ready ? res_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (obuf_ready && res_valid) begin
      data_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_res    = data_r;

endmodule

### hdl/msc_data_group_framer.sv
// MSC data group framer: header, payload pass-through and inverted CRC-16.
// An accepted item is held in the sequencer, and its result bytes are registered
// in the output buffer before out_tdata. One result byte per cycle while the output
// is not stalled; a data item gives one byte (three when it closes the group), a
// header nine bytes (eleven with zero length). A dropped data item gives no byte.
// Reset (rst_n low, synchronous): no group open, CRC at 0xFFFF, output empty.
`timescale 1ns / 1ps

module msc_data_group_framer (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [3:0] group_type, [18:4] segment_number, [19] last_segment,
  // [35:20] transport_id, [48:36] segment_length, [56:49] data_byte, [63:57] zero
  input  logic [msc_dgf_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [0] command
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [7:0] out_byte
  output logic [msc_dgf_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                                out_tlast
);
  import msc_dgf_pkg::*;

  item_t      in_item;
  logic       in_load;
  res_t       res;
  logic       res_valid;
  logic       obuf_ready;
  emit_stat_t stat;
  res_t       out_res;

  always_comb begin
    in_item.cmd            = cmd_t'(in_tuser);
    in_item.group_type     = in_tdata[3:0];
    in_item.segment_number = in_tdata[18:4];
    in_item.last_segment   = in_tdata[19];
    in_item.transport_id   = in_tdata[35:20];
    in_item.segment_length = in_tdata[48:36];
    in_item.data_byte      = in_tdata[56:49];
  end

  // take a new item when idle or when the held one produces its final step
  assign in_tready = !stat.busy || (stat.advance && stat.done);
  assign in_load   = in_tvalid && in_tready;

  msc_dgf_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_load    (in_load),
    .in_item    (in_item),
    .obuf_ready (obuf_ready),
    .res        (res),
    .res_valid  (res_valid),
    .stat       (stat)
  );

  msc_dgf_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .res        (res),
    .res_valid  (res_valid),
    .obuf_ready (obuf_ready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_res    (out_res)
  );

  assign out_tdata = out_res.out_byte;
  assign out_tlast = out_res.end_of_group;

`ifndef SYNTHESIS
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid && !stat.busy)
    else $error("output or sequencer not empty after reset");

  a_hold_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    stat.busy && !stat.advance |-> !in_tready)
    else $error("input taken while the held item is stalled");

  a_accept_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> stat.busy)
    else $error("accepted item not held by the sequencer");
`endif

endmodule

### test/msc_data_group_framer_test.sv
// Self-checking bench for msc_data_group_framer: directed and random header/data items,
// with every output byte checked against a data group predictor.
// Depends on msc_dgf_pkg and the framer RTL only.
`timescale 1ns / 1ps

module msc_data_group_framer_test;
  import msc_dgf_pkg::*;

  // Tracks the open group and the bytes the framer owes us
  class data_group_tracker;
    logic [CRC_W-1:0]  crc;
    logic [SLEN_W-1:0] bytes_left;
    bit                in_group;
    logic [BYTE_W:0]   group_bytes_q[$];   // {byte, end_of_group}
    int                errors;

    function new();
      crc = CRC_INIT;
      bytes_left = '0;
      in_group = 0;
      errors = 0;
    endfunction

    // bit-serial form of the CCITT update
    function logic [CRC_W-1:0] crc_step(logic [CRC_W-1:0] c, logic [BYTE_W-1:0] b);
      logic fb;
      for (int i = BYTE_W - 1; i >= 0; i--) begin
        fb = c[CRC_W-1] ^ b[i];
        c = {c[CRC_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
      end
      return c;
    endfunction

    function void queue_byte(logic [BYTE_W:0] e);
      group_bytes_q = {group_bytes_q, e};
    endfunction

    function void add_byte(logic [BYTE_W-1:0] b);
      crc = crc_step(crc, b);
      queue_byte({b, 1'b0});
    endfunction

    function void close_group();
      logic [CRC_W-1:0] fcs;
      fcs = ~crc;
      queue_byte({fcs[15:8], 1'b0});
      queue_byte({fcs[7:0], 1'b1});
      crc = CRC_INIT;
      bytes_left = '0;
      in_group = 0;
    endfunction

    function void note_item(cmd_t cmd, logic [IN_TDATA_W-1:0] d);
      logic [TYPE_W-1:0] gtype;
      logic [SEGN_W-1:0] segn;
      logic              last;
      logic [TID_W-1:0]  tid;
      logic [SLEN_W-1:0] slen;
      logic [BYTE_W-1:0] payload;
      {payload, slen, tid, last, segn, gtype} = d[56:0];
      if (cmd == CMD_HEADER) begin
        // a header abandons any open group without its CRC
        crc = CRC_INIT;
        add_byte(HDR_FLAGS | {4'h0, gtype});
        add_byte({segn[3:0], 4'h0});
        add_byte({last, segn[14:8]});
        add_byte(segn[7:0]);
        add_byte(HDR_ACCESS);
        add_byte(tid[15:8]);
        add_byte(tid[7:0]);
        add_byte({3'b000, slen[12:8]});
        add_byte(slen[7:0]);
        in_group = 1;
        bytes_left = slen;
        if (slen == 0) close_group();
      end else if (in_group) begin
        add_byte(payload);
        bytes_left = bytes_left - SLEN_W'(1);
        if (bytes_left == 0) close_group();
      end
    endfunction

    function void check_byte(logic [BYTE_W-1:0] b, logic eog);
      logic [BYTE_W:0] exp_b;
      if (group_bytes_q.size() == 0) begin
        $error("unexpected out item: out_byte %h end_of_group %b", b, eog);
        errors++;
        return;
      end
      exp_b = group_bytes_q.pop_front();
      if (b !== exp_b[BYTE_W:1]) begin
        $error("out_byte: expected %h, got %h", exp_b[BYTE_W:1], b);
        errors++;
      end
      if (eog !== exp_b[0]) begin
        $error("end_of_group: expected %b, got %b", exp_b[0], eog);
        errors++;
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;

  data_group_tracker tracker;
  bit quiet;   // when set, neither side idles

  msc_data_group_framer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic logic [IN_TDATA_W-1:0] pack_item(logic [TYPE_W-1:0] gtype,
      logic [SEGN_W-1:0] segn, logic last, logic [TID_W-1:0] tid,
      logic [SLEN_W-1:0] slen, logic [BYTE_W-1:0] payload);
    return {7'b0, payload, slen, tid, last, segn, gtype};
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(cmd_t cmd, logic [IN_TDATA_W-1:0] d);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    tracker.note_item(cmd, d);
    @(negedge clk);
  endtask

  task automatic send_header(logic [TYPE_W-1:0] gtype, logic [SEGN_W-1:0] segn,
                             logic last, logic [TID_W-1:0] tid, logic [SLEN_W-1:0] slen);
    send_item(CMD_HEADER, pack_item(gtype, segn, last, tid, slen,
                                    BYTE_W'($urandom_range(0, 255))));
  endtask

  // header fields ride along with random content and must be ignored
  task automatic send_data(logic [BYTE_W-1:0] payload);
    send_item(CMD_DATA, pack_item(TYPE_W'($urandom_range(0, 15)),
                                  SEGN_W'($urandom_range(0, 32767)),
                                  1'($urandom_range(0, 1)),
                                  TID_W'($urandom_range(0, 65535)),
                                  SLEN_W'($urandom_range(0, 8191)), payload));
  endtask

  task automatic send_group(int slen);
    send_header(TYPE_W'($urandom_range(0, 15)), SEGN_W'($urandom_range(0, 32767)),
                1'($urandom_range(0, 1)), TID_W'($urandom_range(0, 65535)),
                SLEN_W'(slen));
    for (int i = 0; i < slen; i++) send_data(BYTE_W'($urandom_range(0, 255)));
  endtask

  // output side: draws a stall per item, samples at the rising edge
  initial begin
    int gap;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      gap = quiet ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      tracker.check_byte(out_tdata, out_tlast);
      @(negedge clk);
    end
  end

  initial begin
    int sent;
    int pick;
    tracker   = new();
    quiet     = 0;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed
    send_data(8'h5A);                                   // no group open: dropped
    send_header(4'h0, 15'h0000, 1'b0, 16'h0000, 13'h0000);  // empty segment
    send_header(4'hF, 15'h7FFF, 1'b1, 16'hFFFF, 13'h0000);  // empty, all ones
    send_header(4'h4, 15'h0005, 1'b0, 16'h1234, 13'h0003);
    send_data(8'h00);
    send_data(8'hFF);
    send_data(8'hA5);
    send_data(8'h33);                                   // group just closed: dropped
    send_header(4'h3, 15'h0011, 1'b0, 16'hABCD, 13'h1FFF);  // max length, abandoned
    send_data(8'h01);
    send_data(8'h80);
    send_header(4'h4, 15'h4000, 1'b1, 16'h0001, 13'h0001);
    send_data(8'h7E);
    send_header(4'h4, 15'h2AAA, 1'b1, 16'h8000, 13'h1000);  // abandoned
    send_data(8'hC3);
    send_header(4'h3, 15'h5555, 1'b0, 16'h5AA5, 13'h0002);
    send_data(8'h3C);
    send_data(8'h96);

    // random: mostly complete groups, some abandoned ones and stray bytes
    sent = 0;
    while (sent < 330) begin
      if ($urandom_range(0, 7) == 0) quiet = ~quiet;
      pick = $urandom_range(0, 9);
      if (pick == 0 && !tracker.in_group) begin
        send_data(BYTE_W'($urandom_range(0, 255)));
      end else if (pick == 1) begin
        int n;
        n = $urandom_range(0, 4);
        send_header(TYPE_W'($urandom_range(0, 15)), SEGN_W'($urandom_range(0, 32767)),
                    1'($urandom_range(0, 1)), TID_W'($urandom_range(0, 65535)),
                    SLEN_W'($urandom_range(0, 8191)));
        for (int i = 0; i < n; i++) send_data(BYTE_W'($urandom_range(0, 255)));
        sent += n + 1;
      end else begin
        int slen;
        slen = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        send_group(slen);
        sent += slen + 1;
      end
    end
    in_tvalid <= 1'b0;
    quiet = 0;

    while (tracker.group_bytes_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (tracker.errors == 0 && tracker.group_bytes_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
